FILE: hdl/fpld_pkg.sv
// Shared constants, command codes and control structs of the fixed-point line drawer.
package fpld_pkg;

	localparam int COORD_BITS = 9;
	localparam int FRAC_BITS  = 8;
	localparam int ACCUM_BITS = COORD_BITS + 9;
	localparam int INC_BITS   = 10;
	localparam int QUOT_BITS  = FRAC_BITS + 1;
	localparam int DIV_STEPS  = QUOT_BITS;
	localparam int CNT_BITS   = $clog2(DIV_STEPS);
	localparam int ADDR_BITS  = 18;
	localparam int COLOR_BITS = 16;
	localparam int WIDTH_BITS = 10;
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam logic [FRAC_BITS-1:0]  HALF_PIXEL    = 8'h80;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 10'd320;
	localparam logic                  REG_DISPLAY_WIDTH = 1'b0;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_code_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic finish;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

endpackage

FILE: hdl/fpld_ctrl.sv
// Controller of the line drawer: handshakes, divider sequencing and line busy state.
module fpld_ctrl import fpld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       cmd,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                out_valid_q;
	logic                accept;

	assign in_stall  = (state_q == ST_DIV) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.start    = accept && (cmd == CMD_START);
		ctl.emit     = accept && (cmd == CMD_TICK) && busy_q;
		ctl.div_step = (state_q == ST_DIV);
		ctl.finish   = (state_q == ST_DIV) && (cnt_q == CNT_BITS'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (ctl.finish) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (ctl.emit && status.last) begin
				busy_q <= 1'b0;
			end

			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_div_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> in_stall)
		else $error("request accepted while divider runs");
	a_start_divides: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (state_q == ST_DIV) && (cnt_q == '0))
		else $error("start did not launch the divider");
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && status.last) |=> !busy_q)
		else $error("line still busy after last pixel");
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> busy_q && !(state_q == ST_DIV))
		else $error("pixel emitted without an armed line");
	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> out_valid_q)
		else $error("emitted pixel not presented");
`endif

endmodule

FILE: hdl/fpld_dp.sv
// Datapath of the line drawer: setup, slope divider, stepping state and pixel output register.
module fpld_dp import fpld_pkg::*; (
	input  logic                  clk,
	input  dp_cmd_t               ctl,
	output dp_status_t            status,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] draw_color,
	input  logic [WIDTH_BITS-1:0] display_width,
	output logic [ADDR_BITS-1:0]  pixel_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	logic signed [COORD_BITS:0] dx, dy, dx_neg, dy_neg, short_len, long_len;
	logic [COORD_BITS-1:0] adx, ady, abs_short, abs_long;
	logic                  major_y_in;

	logic                  major_is_y_q, step_down_q, neg_q, long_zero_q;
	logic [COORD_BITS-1:0] major_pos_q, major_stop_q;
	logic [ACCUM_BITS-1:0] minor_accum_q;
	logic [INC_BITS-1:0]   minor_inc_q;
	logic [COLOR_BITS-1:0] held_color_q;

	logic [COORD_BITS-1:0] div_d_q, rem_q;
	logic [FRAC_BITS:0]    low_q;
	logic [QUOT_BITS-1:0]  quot_q;
	logic [COORD_BITS:0]   trial, diff;
	logic                  qbit;
	logic [QUOT_BITS-1:0]  quot_next;
	logic [INC_BITS-1:0]   q_ext, inc_next;

	logic [COORD_BITS-1:0]            minor, px, py;
	logic [WIDTH_BITS+COORD_BITS-1:0] prod;
	logic [ADDR_BITS-1:0]             addr;
	logic [ACCUM_BITS-1:0]            inc_ext;

	logic [ADDR_BITS-1:0]  pixel_address_q;
	logic [COLOR_BITS-1:0] pixel_color_q;
	logic                  last_pixel_q;

	always_comb begin
		dx         = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy         = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		dx_neg     = -dx;
		dy_neg     = -dy;
		adx        = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady        = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		major_y_in = ady > adx;
		short_len  = major_y_in ? dx : dy;
		long_len   = major_y_in ? dy : dx;
		abs_short  = major_y_in ? adx : ady;
		abs_long   = major_y_in ? ady : adx;
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, low_q[FRAC_BITS]};
		diff      = trial - {1'b0, div_d_q};
		qbit      = (trial >= {1'b0, div_d_q});
		quot_next = {quot_q[QUOT_BITS-2:0], qbit};
		q_ext     = INC_BITS'(quot_next);
		inc_next  = long_zero_q ? '0 : (neg_q ? (~q_ext + 1'b1) : q_ext);
	end

	always_comb begin
		minor   = minor_accum_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
		px      = major_is_y_q ? minor : major_pos_q;
		py      = major_is_y_q ? major_pos_q : minor;
		prod    = {{COORD_BITS{1'b0}}, display_width} * {{WIDTH_BITS{1'b0}}, py};
		addr    = prod[ADDR_BITS-1:0] + ADDR_BITS'(px);
		inc_ext = {{(ACCUM_BITS-INC_BITS){minor_inc_q[INC_BITS-1]}}, minor_inc_q};
		status.last = (major_pos_q == major_stop_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			major_is_y_q  <= major_y_in;
			major_pos_q   <= major_y_in ? y_start : x_start;
			major_stop_q  <= major_y_in ? y_end : x_end;
			minor_accum_q <= ACCUM_BITS'({(major_y_in ? x_start : y_start), HALF_PIXEL});
			step_down_q   <= long_len[COORD_BITS] || (long_len == '0);
			neg_q         <= short_len[COORD_BITS] ^ long_len[COORD_BITS];
			long_zero_q   <= (long_len == '0);
			held_color_q  <= {draw_color[7:0], draw_color[15:8]};
			div_d_q       <= abs_long;
			rem_q         <= {1'b0, abs_short[COORD_BITS-1:1]};
			low_q         <= {abs_short[0], {FRAC_BITS{1'b0}}};
			quot_q        <= '0;
		end else if (ctl.div_step) begin
			rem_q  <= qbit ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			low_q  <= {low_q[FRAC_BITS-1:0], 1'b0};
			quot_q <= quot_next;
			if (ctl.finish) begin
				minor_inc_q <= inc_next;
			end
		end else if (ctl.emit) begin
			pixel_address_q <= addr;
			pixel_color_q   <= held_color_q;
			last_pixel_q    <= status.last;
			if (!status.last) begin
				if (step_down_q) begin
					major_pos_q   <= major_pos_q - 1'b1;
					minor_accum_q <= minor_accum_q - inc_ext;
				end else begin
					major_pos_q   <= major_pos_q + 1'b1;
					minor_accum_q <= minor_accum_q + inc_ext;
				end
			end
		end
	end

	assign pixel_address = pixel_address_q;
	assign pixel_color   = pixel_color_q;
	assign last_pixel    = last_pixel_q;

endmodule

FILE: hdl/fixed_point_line_drawer.sv
// Top level of the fixed-point line drawer: register port, controller and datapath.
//
//  channel  | handshake           | payload
//  in       | in_valid / in_stall | cmd, x_start, y_start, x_end, y_end, draw_color
//  out      | out_valid/out_stall | pixel_address, pixel_color, last_pixel
//  register | APB write/read      | display_width at byte address 0
//
// Tick requests give one pixel per clock while out_stall stays low.
// After a start request is accepted, in_stall stays high while the
// restoring divider produces one slope bit per cycle.
// Outside the divide, in_stall rises only while a pixel waits under out_stall.
// Reset idles the controller and clears the line busy state; display_width returns to 320.
module fixed_point_line_drawer import fpld_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] draw_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ADDR_BITS-1:0]  pixel_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	logic [WIDTH_BITS-1:0] display_width_q;
	logic                  reg_sel;
	dp_cmd_t               ctl;
	dp_status_t            status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_DISPLAY_WIDTH);
	assign prdata  = reg_sel ? PDATA_BITS'(display_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_width_q <= WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			display_width_q <= pwdata[WIDTH_BITS-1:0];
		end
	end

	fpld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ctl       (ctl)
	);

	fpld_dp u_dp (
		.clk           (clk),
		.ctl           (ctl),
		.status        (status),
		.x_start       (x_start),
		.y_start       (y_start),
		.x_end         (x_end),
		.y_end         (y_end),
		.draw_color    (draw_color),
		.display_width (display_width_q),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last_pixel    (last_pixel)
	);

endmodule
